[hw/rtl/sqs_pkg.sv]
// package: shared types and codes for the double-ended word store
`timescale 1ns / 1ps
package sqs_pkg;

  localparam int WORD_W  = 32;
  localparam int COUNT_W = 7;

  typedef logic signed [WORD_W-1:0] word_t;

  // operation codes
  localparam logic [1:0] KIND_PUSH      = 2'd0;
  localparam logic [1:0] KIND_POP_BACK  = 2'd1;
  localparam logic [1:0] KIND_POP_FRONT = 2'd2;
  localparam logic [1:0] KIND_SEARCH    = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_EMPTY    = 2'd1;
  localparam logic [1:0] STAT_FULL     = 2'd2;
  localparam logic [1:0] STAT_NO_MATCH = 2'd3;

  localparam word_t NO_DATA = -32'sd1;

  typedef struct packed {
    logic [1:0] kind;
    word_t      value;
  } cmd_t;

  typedef struct packed {
    word_t              data;
    logic [1:0]         status;
    logic [COUNT_W-1:0] item_count;
    logic               is_empty_flag;
    logic               last;
  } result_t;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop_front;
    logic pop_back;
    logic load_match;
    logic shift_match;
  } cell_ctrl_t;

endpackage

[hw/rtl/sqs_cell.sv]
// module: one storage cell of the word chain, front end at cell zero
`timescale 1ns / 1ps
module sqs_cell (
  input  logic                clk,
  input  logic                rst,
  input  sqs_pkg::cell_ctrl_t ctrl,
  input  sqs_pkg::word_t      value,
  input  logic                prev_valid,
  input  sqs_pkg::word_t      next_data,
  input  logic                next_valid,
  input  logic                next_match,
  output sqs_pkg::word_t      data,
  output logic                valid,
  output logic                match
);

  logic is_tail;
  logic is_slot;

  assign is_tail = valid && !next_valid;
  assign is_slot = !valid && prev_valid;

  // payload, no reset
  always_ff @(posedge clk) begin
    if (ctrl.pop_front) begin
      data <= next_data;
    end else if (ctrl.push && is_slot) begin
      data <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      match <= 1'b0;
    end else begin
      if (ctrl.pop_front) begin
        valid <= next_valid;
      end else if (ctrl.push && is_slot) begin
        valid <= 1'b1;
      end else if (ctrl.pop_back && is_tail) begin
        valid <= 1'b0;
      end
      if (ctrl.load_match) begin
        match <= valid && (data == value);
      end else if (ctrl.shift_match) begin
        match <= next_match;
      end
    end
  end

endmodule

[hw/rtl/stack_queue_with_search_top.sv]
// module: top level of the double-ended word store with search
`timescale 1ns / 1ps
// push, pop back and pop front: result registered, in the cycle after the transfer; one item per cycle while not busy
// search: match flags load in the transfer cycle, then the chain shifts one cell per cycle;
//   busy until the result for the last match, or the no-match result, has been given
// results appear for exactly one cycle on strobe; the receiver cannot stall
// reset (synchronous, active high) clears valid bits, count and control; words are not cleared
module stack_queue_with_search_top #(
  parameter int DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  sqs_pkg::cmd_t    cmd,
  output logic             strobe,
  output sqs_pkg::result_t result
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic {ST_IDLE, ST_SCAN} state_t;

  state_t  state;
  logic [CW-1:0] count;
  logic [PW-1:0] pos;

  // chain wiring; index DEPTH is the empty neighbour past the back end
  sqs_pkg::word_t cell_data  [DEPTH+1];
  logic [DEPTH:0] cell_valid;
  logic [DEPTH:0] cell_match;

  sqs_pkg::cell_ctrl_t ctrl;
  logic accept;
  logic full;
  logic empty;
  logic any_match;
  logic rest_match;
  sqs_pkg::word_t tail_data;

  assign busy      = (state == ST_SCAN);
  assign accept    = start && !busy;
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign any_match = |cell_match[DEPTH-1:0];
  assign rest_match = |cell_match[DEPTH-1:1];

  assign cell_data[DEPTH]  = '0;
  assign cell_valid[DEPTH] = 1'b0;
  assign cell_match[DEPTH] = 1'b0;

  // control broadcast to the chain
  always_comb begin
    ctrl = '0;
    if (accept) begin
      unique case (cmd.kind)
        sqs_pkg::KIND_PUSH:      ctrl.push       = !full;
        sqs_pkg::KIND_POP_BACK:  ctrl.pop_back   = !empty;
        sqs_pkg::KIND_POP_FRONT: ctrl.pop_front  = !empty;
        sqs_pkg::KIND_SEARCH:    ctrl.load_match = 1'b1;
        default:                 ctrl = '0;
      endcase
    end
    ctrl.shift_match = busy && any_match;
  end

  // the back word is held by the single valid cell whose neighbour is empty
  always_comb begin
    tail_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_valid[i] && !cell_valid[i+1]) begin
        tail_data = tail_data | cell_data[i];
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    sqs_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .value      (cmd.value),
      .prev_valid ((g == 0) ? 1'b1 : cell_valid[(g == 0) ? 0 : g-1]),
      .next_data  (cell_data[g+1]),
      .next_valid (cell_valid[g+1]),
      .next_match (cell_match[g+1]),
      .data       (cell_data[g]),
      .valid      (cell_valid[g]),
      .match      (cell_match[g])
    );
  end

  // state, count and the registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= '0;
      pos    <= '0;
      strobe <= 1'b0;
      result <= '0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (cmd.kind)
              sqs_pkg::KIND_PUSH: begin
                strobe      <= 1'b1;
                result.data <= '0;
                result.last <= 1'b1;
                if (full) begin
                  result.status        <= sqs_pkg::STAT_FULL;
                  result.item_count    <= sqs_pkg::COUNT_W'(count);
                  result.is_empty_flag <= empty;
                end else begin
                  count                <= count + 1'b1;
                  result.status        <= sqs_pkg::STAT_OK;
                  result.item_count    <= sqs_pkg::COUNT_W'(count + 1'b1);
                  result.is_empty_flag <= 1'b0;
                end
              end
              sqs_pkg::KIND_POP_BACK, sqs_pkg::KIND_POP_FRONT: begin
                strobe      <= 1'b1;
                result.last <= 1'b1;
                if (empty) begin
                  result.data          <= sqs_pkg::NO_DATA;
                  result.status        <= sqs_pkg::STAT_EMPTY;
                  result.item_count    <= '0;
                  result.is_empty_flag <= 1'b1;
                end else begin
                  count                <= count - 1'b1;
                  result.data          <= (cmd.kind == sqs_pkg::KIND_POP_BACK) ?
                                          tail_data : cell_data[0];
                  result.status        <= sqs_pkg::STAT_OK;
                  result.item_count    <= sqs_pkg::COUNT_W'(count - 1'b1);
                  result.is_empty_flag <= (count == CW'(1));
                end
              end
              sqs_pkg::KIND_SEARCH: begin
                state <= ST_SCAN;
                pos   <= '0;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_SCAN: begin
          // count is unchanged by search
          result.item_count    <= sqs_pkg::COUNT_W'(count);
          result.is_empty_flag <= empty;
          pos                  <= pos + 1'b1;
          if (!any_match) begin
            strobe        <= 1'b1;
            result.data   <= sqs_pkg::NO_DATA;
            result.status <= sqs_pkg::STAT_NO_MATCH;
            result.last   <= 1'b1;
            state         <= ST_IDLE;
          end else if (cell_match[0]) begin
            strobe        <= 1'b1;
            result.data   <= sqs_pkg::word_t'(32'(pos));
            result.status <= sqs_pkg::STAT_OK;
            result.last   <= !rest_match;
            if (!rest_match) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/sqs_checker.sv]
// module: port-level checker for the double-ended word store, bound to the top level
`timescale 1ns / 1ps
module sqs_checker #(
  parameter int DEPTH = 64
) (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input sqs_pkg::cmd_t    cmd,
  input logic             strobe,
  input sqs_pkg::result_t result
);

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd.kind != sqs_pkg::KIND_SEARCH)) |=> (strobe && result.last))
    else $error("push or pop transfer gave no single final result");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (result.is_empty_flag == (result.item_count == '0)))
    else $error("empty flag disagrees with count");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (result.item_count <= sqs_pkg::COUNT_W'(DEPTH)))
    else $error("count beyond depth");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (strobe && (result.status == sqs_pkg::STAT_FULL))
      |-> (result.item_count == sqs_pkg::COUNT_W'(DEPTH)))
    else $error("full status while not full");

  a_more_pending: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.last) |-> busy)
    else $error("non-final result while idle");

endmodule

bind stack_queue_with_search_top sqs_checker #(.DEPTH(DEPTH)) u_sqs_checker (.*);

[dv/testbench.sv]
// testbench: self-checking bench for the double-ended word store with search
`timescale 1ns / 1ps
module testbench;
  import sqs_pkg::*;

  localparam int DEPTH = 64;

  // one queued command, with the idle cycles to insert before it and an
  // optional hold until every outstanding result has arrived
  typedef struct {
    cmd_t        c;
    int unsigned gap;
    bit          drain_first;
  } stim_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  cmd_t    cmd = '0;
  logic    strobe;
  result_t result;

  stack_queue_with_search_top #(.DEPTH(DEPTH)) DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .strobe (strobe),
    .result (result)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // commands waiting to be driven, and results the store must still produce
  stim_t   pending_cmds[$];
  result_t expected_results[$];

  // shadow copy of the store: ring of words, oldest-word index, word count
  word_t              shadow_words[DEPTH];
  int unsigned        head_idx = 0;
  logic [COUNT_W-1:0] fill_count = '0;

  // transfer seen at the last rising edge
  logic took_q = 1'b0;

  int mismatch_count = 0;
  int n_items = 0, n_push = 0, n_full = 0, n_pop = 0, n_empty_pop = 0;
  int n_search = 0, n_hits = 0, n_miss = 0, peak_fill = 0;

  // apply one command to the shadow store and queue the results it causes
  function automatic void apply_store_op(cmd_t c);
    result_t     r;
    int unsigned slot;
    int          hits;
    r    = '0;
    hits = 0;
    r.last = 1'b1;
    n_items++;
    case (c.kind)
      KIND_PUSH: begin
        n_push++;
        if (fill_count >= DEPTH) begin
          r.status = STAT_FULL;
          n_full++;
        end else begin
          shadow_words[(head_idx + fill_count) % DEPTH] = c.value;
          fill_count++;
          r.status = STAT_OK;
        end
      end
      KIND_POP_BACK, KIND_POP_FRONT: begin
        n_pop++;
        if (fill_count == 0) begin
          r.data   = NO_DATA;
          r.status = STAT_EMPTY;
          n_empty_pop++;
        end else begin
          if (c.kind == KIND_POP_BACK) begin
            r.data = shadow_words[(head_idx + fill_count - 1) % DEPTH];
          end else begin
            r.data   = shadow_words[head_idx];
            head_idx = (head_idx + 1) % DEPTH;
          end
          fill_count--;
          r.status = STAT_OK;
        end
      end
      default: begin
        // search walks front to back, one result per matching word
        n_search++;
        r.status = STAT_OK;
        r.last   = 1'b0;
        r.item_count    = fill_count;
        r.is_empty_flag = (fill_count == 0);
        for (int i = 0; i < fill_count; i++) begin
          slot = (head_idx + i) % DEPTH;
          if (shadow_words[slot] == c.value) begin
            r.data = word_t'(i);
            expected_results.push_back(r);
            hits++;
          end
        end
        n_hits += hits;
        if (hits == 0) begin
          r.data   = NO_DATA;
          r.status = STAT_NO_MATCH;
          r.last   = 1'b1;
          n_miss++;
        end else begin
          expected_results[expected_results.size() - 1].last = 1'b1;
          return;
        end
      end
    endcase
    r.item_count    = fill_count;
    r.is_empty_flag = (fill_count == 0);
    if (int'(fill_count) > peak_fill) peak_fill = fill_count;
    expected_results.push_back(r);
  endfunction

  // compare one strobed result with the oldest expectation
  function automatic void check_result(result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      $error("unexpected result: data %0d status %0d", got.data, got.status);
      mismatch_count++;
      return;
    end
    want = expected_results.pop_front();
    if (got.data !== want.data) begin
      $error("data: expected %0d, got %0d", want.data, got.data);
      mismatch_count++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      mismatch_count++;
    end
    if (got.item_count !== want.item_count) begin
      $error("item_count: expected %0d, got %0d", want.item_count, got.item_count);
      mismatch_count++;
    end
    if (got.is_empty_flag !== want.is_empty_flag) begin
      $error("is_empty_flag: expected %0d, got %0d", want.is_empty_flag, got.is_empty_flag);
      mismatch_count++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, got.last);
      mismatch_count++;
    end
  endfunction

  // monitor: sample on the rising edge; check results first, then predict
  // for a command transferred on the same edge
  always @(posedge clk) begin
    if (rst) begin
      took_q <= 1'b0;
    end else begin
      if (strobe) check_result(result);
      took_q <= start && !busy;
      if (start && !busy) apply_store_op(cmd);
    end
  end

  // driver: changes inputs on the falling edge; a new command goes out only
  // once the previous one has been transferred (or start was low)
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || took_q) begin
      if (pending_cmds.size() == 0) begin
        start <= 1'b0;
      end else if (pending_cmds[0].drain_first && expected_results.size() != 0) begin
        // hold off until the store has delivered everything outstanding
        start <= 1'b0;
      end else if (pending_cmds[0].gap != 0) begin
        start <= 1'b0;
        pending_cmds[0].gap = pending_cmds[0].gap - 1;
      end else begin
        cmd   <= pending_cmds[0].c;
        start <= 1'b1;
        void'(pending_cmds.pop_front());
      end
    end
  end

  // mostly a small pool of words so that searches hit, often several times;
  // the rest fully random so every bit toggles
  function automatic word_t pick_word();
    word_t pool[8];
    pool = '{32'sd0, -32'sd1, 32'sd1, 32'sd7, 32'h8000_0000, 32'h7fff_ffff,
             32'h5555_5555, 32'haaaa_aaaa};
    if ($urandom_range(0, 9) < 6) return pool[$urandom_range(0, 7)];
    return word_t'($urandom());
  endfunction

  task automatic queue_op(logic [1:0] kind, word_t value, int unsigned gap, bit drain);
    stim_t s;
    s.c.kind      = kind;
    s.c.value     = value;
    s.gap         = gap;
    s.drain_first = drain;
    pending_cmds.push_back(s);
  endtask

  // random phase with the given mix (percent); search takes what is left over
  task automatic queue_random(int n, int push_pct, int popb_pct, int popf_pct, bit quiet);
    int          roll;
    bit          calm;
    int unsigned gap;
    logic [1:0]  kind;
    calm = 1'b0;
    for (int i = 0; i < n; i++) begin
      // idle bursts come in stretches, some stretches have none at all
      if (i % 20 == 0) calm = ($urandom_range(0, 2) == 0);
      gap = 0;
      if (!quiet && !calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 16);
      roll = $urandom_range(0, 99);
      if (roll < push_pct) kind = KIND_PUSH;
      else if (roll < push_pct + popb_pct) kind = KIND_POP_BACK;
      else if (roll < push_pct + popb_pct + popf_pct) kind = KIND_POP_FRONT;
      else kind = KIND_SEARCH;
      queue_op(kind, pick_word(), gap, i == 0);
    end
  endtask

  initial begin
    // directed: empty-store corner cases, extreme words, duplicate matches,
    // search for the same pattern as the no-data marker, pops ignoring value
    queue_op(KIND_POP_BACK,  word_t'($urandom()), 0, 0);
    queue_op(KIND_POP_FRONT, word_t'($urandom()), 0, 0);
    queue_op(KIND_SEARCH,    32'sd0, 0, 0);
    queue_op(KIND_PUSH,      32'h7fff_ffff, 0, 0);
    queue_op(KIND_PUSH,      32'h8000_0000, 0, 0);
    queue_op(KIND_PUSH,      -32'sd1, 0, 0);
    queue_op(KIND_PUSH,      32'sd0, 2, 0);
    queue_op(KIND_PUSH,      -32'sd1, 0, 0);
    queue_op(KIND_SEARCH,    -32'sd1, 0, 0);
    queue_op(KIND_SEARCH,    32'h8000_0000, 0, 0);
    queue_op(KIND_SEARCH,    32'sd12345, 0, 0);
    queue_op(KIND_POP_BACK,  32'h7fff_ffff, 0, 0);
    queue_op(KIND_POP_FRONT, 32'sd0, 0, 0);
    queue_op(KIND_SEARCH,    -32'sd1, 3, 0);
    queue_op(KIND_POP_BACK,  32'sd0, 0, 0);
    queue_op(KIND_POP_BACK,  32'sd0, 0, 0);
    queue_op(KIND_POP_FRONT, 32'sd0, 0, 0);
    queue_op(KIND_POP_FRONT, 32'sd0, 0, 0);
    queue_op(KIND_SEARCH,    -32'sd1, 0, 1);
    queue_op(KIND_PUSH,      32'haaaa_aaaa, 0, 0);
    queue_op(KIND_SEARCH,    32'haaaa_aaaa, 0, 0);

    // fill past the top so full pushes get refused and searches walk every entry
    queue_random(90, 90, 0, 0, 1'b0);
    // churn around a high fill level; pop-front traffic wraps the ring
    queue_random(110, 35, 10, 35, 1'b0);
    // drain towards empty, then pops and searches on an empty store
    queue_random(60, 10, 30, 45, 1'b0);
    // last part: mixed traffic, back to back with no idling
    queue_random(40, 40, 15, 20, 1'b1);

    // reset held at start-up, released on a falling edge
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() != 0 || start) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    // a full-depth search is the longest the store can stay busy
    repeat (DEPTH + 8) @(posedge clk);

    $display("testbench: %0d commands: %0d pushes (%0d refused when full), %0d pops (%0d on empty)",
             n_items, n_push, n_full, n_pop, n_empty_pop);
    $display("testbench: %0d searches, %0d matches, %0d with no match, fill peaked at %0d",
             n_search, n_hits, n_miss, peak_fill);
    if (mismatch_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/sqs_pkg.sv
hw/rtl/sqs_cell.sv
hw/rtl/stack_queue_with_search_top.sv
hw/rtl/sqs_checker.sv
dv/testbench.sv
